/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine: input and result
// words, command codes, phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int unsigned HALF_W = 9;

	// command codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [HALF_W-1:0] HALF_RESET = 9'd10;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] req_type;
		logic [7:0] write_byte;
		logic       master_ack;
		logic       sda_in;
	} i2cm_in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_seen;
	} i2cm_out_t;

	typedef enum logic [14:0] {
		PH_IDLE = 15'b000000000000001,
		PH_ST0  = 15'b000000000000010,
		PH_ST1  = 15'b000000000000100,
		PH_ST2  = 15'b000000000001000,
		PH_SP0  = 15'b000000000010000,
		PH_SP1  = 15'b000000000100000,
		PH_SP2  = 15'b000000001000000,
		PH_WHI  = 15'b000000010000000,
		PH_WLO  = 15'b000000100000000,
		PH_WAH  = 15'b000001000000000,
		PH_WAL  = 15'b000010000000000,
		PH_RHI  = 15'b000100000000000,
		PH_RLO  = 15'b001000000000000,
		PH_RAH  = 15'b010000000000000,
		PH_RAL  = 15'b100000000000000
	} i2cm_phase_t;

endpackage

`default_nettype wire

/* rtl/core/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine: one input word per bus tick, one result word per
// input word carrying the SCL/SDA levels and command status.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake              Word
// in        in    in_valid / in_ready    i2cm_in_t  (command, write byte, SDA sample)
// out       out   out_valid / out_ready  i2cm_out_t (SCL, SDA, busy, done, data, nack)
// cfg       in    cfg_valid / cfg_ready  9-bit half period, ticks per SCL half
//
// One word enters every cycle while in_ready is high; its result is in the
// output register on the next cycle.
// The sequencer state and the result register are the only timing path.
// The output register drains and refills in the same cycle; in_ready drops
// only while a result waits and out_ready is low, which freezes the engine.
// Reset clears the engine to idle with SCL and SDA released; half period is 10.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  i2cm_pkg::i2cm_in_t            in_data,
	output logic                          out_valid,
	input  wire                           out_ready,
	output i2cm_pkg::i2cm_out_t           out_data,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [i2cm_pkg::HALF_W-1:0]    cfg_data
);
	import i2cm_pkg::*;

	logic              fire;
	logic              room;
	logic [HALF_W-1:0] half_q;
	i2cm_out_t         step_res;

	// accept a word whenever the result register can take its result
	assign in_ready  = room;
	assign fire      = in_valid && room;
	assign cfg_ready = 1'b1;

	// hold the half period; a new value times the next phase that starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_valid) begin
			half_q <= cfg_data;
		end
	end

	// advance the bus sequencer by one tick per accepted word
	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (in_data),
		.half_period (half_q),
		.result      (step_res)
	);

	// register the result word toward the consumer
	i2cm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.din       (step_res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// every accepted word yields a result on the next cycle
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("accepted word produced no result");

	// a completing command reports not busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.done_res) |-> !out_data.busy_res)
		else $error("done reported while busy");

endmodule

`default_nettype wire

/* rtl/core/i2cm_core.sv */
// ----------------------------------------------------------------------------
// i2cm_core
// Bus phase sequencer: holds the engine state and advances it by one tick
// for every accepted word; presents the result word of that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          fire,
	input  i2cm_pkg::i2cm_in_t           item,
	input  wire [i2cm_pkg::HALF_W-1:0]   half_period,
	output i2cm_pkg::i2cm_out_t          result
);
	import i2cm_pkg::*;

	i2cm_phase_t       phase_q, phase_d;
	logic [3:0]        bit_cnt_q, bit_cnt_d;
	logic [7:0]        shift_q, shift_d;
	logic [HALF_W-1:0] delay_q, delay_d;
	logic              scl_q, scl_d;
	logic              sda_q, sda_d;
	logic              nack_q, nack_d;
	logic              ack_q, ack_d;
	logic [7:0]        rdata_q, rdata_d;
	logic              done;
	logic [HALF_W-1:0] hlen;
	logic [3:0]        bit_inc;

	// zero half period counts as one tick
	assign hlen    = (half_period == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_period;
	assign bit_inc = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		delay_d   = delay_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		nack_d    = nack_q;
		ack_d     = ack_q;
		rdata_d   = rdata_q;
		done      = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd_valid) begin
				delay_d = hlen;
				case (item.req_type)
					REQ_START: begin
						phase_d = PH_ST0;
						scl_d   = 1'b1;
						sda_d   = 1'b1;
						delay_d = {{(HALF_W-1){1'b0}}, 1'b1};
					end
					REQ_STOP: begin
						phase_d = PH_SP0;
						sda_d   = 1'b0;
					end
					REQ_WRITE: begin
						phase_d   = PH_WHI;
						shift_d   = item.write_byte;
						bit_cnt_d = '0;
						scl_d     = 1'b1;
						sda_d     = item.write_byte[7];
					end
					default: begin
						phase_d   = PH_RHI;
						shift_d   = '0;
						bit_cnt_d = '0;
						ack_d     = item.master_ack;
						scl_d     = 1'b1;
						sda_d     = 1'b1;
					end
				endcase
			end
		end else begin
			delay_d = delay_q - {{(HALF_W-1){1'b0}}, 1'b1};
			if (delay_d == '0) begin
				delay_d = hlen;
				case (phase_q)
					PH_ST0: begin phase_d = PH_ST1; scl_d = 1'b1; sda_d = 1'b0; end
					PH_ST1: begin phase_d = PH_ST2; scl_d = 1'b0; sda_d = 1'b0; end
					PH_SP0: begin phase_d = PH_SP1; scl_d = 1'b1; sda_d = 1'b0; end
					PH_SP1: begin phase_d = PH_SP2; scl_d = 1'b1; sda_d = 1'b1; end
					PH_WHI: begin phase_d = PH_WLO; scl_d = 1'b0; end
					PH_WLO: begin
						shift_d   = {shift_q[6:0], 1'b0};
						bit_cnt_d = bit_inc;
						scl_d     = 1'b1;
						if (bit_inc[3]) begin
							phase_d = PH_WAH;
							sda_d   = 1'b1;
						end else begin
							phase_d = PH_WHI;
							sda_d   = shift_q[6];
						end
					end
					PH_WAH: begin
						nack_d  = item.sda_in;
						phase_d = PH_WAL;
						scl_d   = 1'b0;
						sda_d   = 1'b1;
					end
					PH_RHI: begin
						shift_d = {shift_q[6:0], item.sda_in};
						phase_d = PH_RLO;
						scl_d   = 1'b0;
						sda_d   = 1'b1;
					end
					PH_RLO: begin
						bit_cnt_d = bit_inc;
						scl_d     = 1'b1;
						if (bit_inc[3]) begin
							rdata_d = shift_q;
							phase_d = PH_RAH;
							sda_d   = ~ack_q;
						end else begin
							phase_d = PH_RHI;
							sda_d   = 1'b1;
						end
					end
					PH_RAH: begin phase_d = PH_RAL; scl_d = 1'b0; end
					default: begin
						// closing phase of any command: back to idle
						phase_d = PH_IDLE;
						delay_d = '0;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		result.scl_level = scl_d;
		result.sda_drive = sda_d;
		result.busy_res  = (phase_d != PH_IDLE);
		result.done_res  = done;
		result.read_data = rdata_d;
		result.nack_seen = nack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			delay_q   <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			nack_q    <= 1'b0;
			ack_q     <= 1'b0;
			rdata_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			delay_q   <= delay_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			nack_q    <= nack_d;
			ack_q     <= ack_d;
			rdata_q   <= rdata_d;
		end
	end

	// the delay counter is zero exactly while idle
	a_idle_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (delay_q == '0))
		else $error("delay counter out of step with phase");

	// bit counter never passes eight
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= 4'd8)
		else $error("bit counter overran");

endmodule

`default_nettype wire

/* rtl/core/i2cm_obuf.sv */
// ----------------------------------------------------------------------------
// i2cm_obuf
// Result register: holds one result word until the consumer takes it and
// lets a new word in the same cycle the held one drains.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_obuf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  i2cm_pkg::i2cm_out_t  din,
	output logic                 room,
	output logic                 out_valid,
	input  wire                  out_ready,
	output i2cm_pkg::i2cm_out_t  out_data
);
	import i2cm_pkg::*;

	logic      valid_q;
	i2cm_out_t data_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	// a waiting word stays put until taken
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("waiting result word changed or dropped");

endmodule

`default_nettype wire

/* bench/i2c_master_byte_engine_tb.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine. Every input word is one
// bus tick; a local model of the phase sequencer predicts the SCL/SDA levels,
// busy/done flags, read byte and no-ack flag for each accepted word, and each
// result word is compared field by field, in order. A short table of commands
// comes first, opening at the reset half period. Random transfers follow over
// several half-period settings, with both handshakes stalling in bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	// long receiver hold, enough to stall the input side
	localparam int unsigned LONG_HOLD   = 200;

	typedef enum {SEG_PLAIN, SEG_HOLD, SEG_PAUSE, SEG_CALM} seg_mode_t;

	// one directed command: the word that issues it, the word offered on every
	// tick while it runs, and the first-tick levels where they are obvious
	typedef struct {
		i2cm_in_t  cmd;
		i2cm_in_t  fill;
		bit        known;
		i2cm_out_t first;
	} cmd_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	i2cm_in_t            in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	i2cm_out_t           out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [HALF_W-1:0]   cfg_data  = HALF_RESET;

	// model of the engine: phase sequencer, shifter and sticky flags
	i2cm_phase_t         m_phase = PH_IDLE;
	logic [3:0]          m_bits  = '0;
	logic [7:0]          m_shift = '0;
	logic [HALF_W-1:0]   m_delay = '0;
	logic                m_scl   = 1'b1;
	logic                m_sda   = 1'b1;
	logic                m_nack  = 1'b0;
	logic                m_ack   = 1'b0;
	logic [7:0]          m_rd    = '0;
	logic [HALF_W-1:0]   m_half  = HALF_RESET;

	i2cm_out_t           pending_levels[$];
	i2cm_in_t            txn_q[$];
	int unsigned         fail_count = 0;
	int unsigned         cycles     = 0;

	// handshake between the sender and the receiver process
	int unsigned         hold_reqs  = 0;
	int unsigned         hold_seen  = 0;
	int unsigned         rx_gap     = 0;
	logic                calm       = 1'b0;

	// Directed commands: the idle tick and the first start run at the reset
	// half period of 10 ticks, the rest at a half period of 2. Levels are
	// {scl, sda, busy, done, read_data, nack}.
	cmd_row_t dir_rows [0:14] = '{
		// idle tick straight after reset
		'{{1'b0, REQ_START, 8'h00, 1'b0, 1'b0}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b0},
		  1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		// start with the unused fields all high
		'{{1'b1, REQ_START, 8'hFF, 1'b1, 1'b1}, {1'b0, REQ_STOP, 8'h00, 1'b0, 1'b1},
		  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		// all-ones byte, slave leaves SDA high: no acknowledge
		'{{1'b1, REQ_WRITE, 8'hFF, 1'b0, 1'b0}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b1},
		  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		// all-zeros byte, acknowledged; no-ack flag still set on the first tick
		'{{1'b1, REQ_WRITE, 8'h00, 1'b1, 1'b1}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b0},
		  1'b1, {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
		// read all ones and answer ACK
		'{{1'b1, REQ_READ, 8'h00, 1'b1, 1'b0}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b1},
		  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		// read all zeros and answer NACK
		'{{1'b1, REQ_READ, 8'hFF, 1'b0, 1'b1}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b0},
		  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0}},
		// stop from SCL low keeps SCL low while SDA drops
		'{{1'b1, REQ_STOP, 8'h5A, 1'b1, 1'b0}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b1},
		  1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
		// stop from SCL high
		'{{1'b1, REQ_STOP, 8'h00, 1'b0, 1'b1}, {1'b0, REQ_START, 8'h00, 1'b0, 1'b0},
		  1'b1, {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
		// commands offered while busy are dropped
		'{{1'b1, REQ_START, 8'h00, 1'b0, 1'b0}, {1'b1, REQ_WRITE, 8'hA5, 1'b1, 1'b0},
		  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{{1'b1, REQ_WRITE, 8'hA5, 1'b0, 1'b0}, {1'b1, REQ_READ, 8'h3C, 1'b1, 1'b1},
		  1'b0, '0},
		'{{1'b1, REQ_READ, 8'h96, 1'b1, 1'b1}, {1'b1, REQ_START, 8'hC3, 1'b0, 1'b1},
		  1'b0, '0},
		'{{1'b1, REQ_WRITE, 8'h5A, 1'b1, 1'b1}, {1'b1, REQ_STOP, 8'h00, 1'b1, 1'b0},
		  1'b0, '0},
		// repeated start from SCL low
		'{{1'b1, REQ_START, 8'h7E, 1'b0, 1'b1}, {1'b1, REQ_READ, 8'h81, 1'b0, 1'b0},
		  1'b0, '0},
		'{{1'b1, REQ_READ, 8'h24, 1'b0, 1'b0}, {1'b0, REQ_WRITE, 8'hDB, 1'b1, 1'b0},
		  1'b0, '0},
		'{{1'b1, REQ_STOP, 8'hE7, 1'b0, 1'b1}, {1'b1, REQ_WRITE, 8'h18, 1'b1, 1'b1},
		  1'b0, '0}
	};

	i2c_master_byte_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hold reset from the start, then release it for good
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- model

	function automatic void enter_phase(input i2cm_phase_t p, input logic scl,
			input logic sda, input logic [HALF_W-1:0] len);
		m_phase = p;
		m_scl   = scl;
		m_sda   = sda;
		m_delay = len;
	endfunction

	// Advance the model by one bus tick and return the levels it shows.
	function automatic i2cm_out_t step_engine(input i2cm_in_t w);
		logic [HALF_W-1:0] len;
		logic              fin;
		i2cm_out_t         lv;
		// a zero half period still lasts one tick
		len = (m_half == '0) ? 9'd1 : m_half;
		fin = 1'b0;
		lv  = '0;
		if (m_phase == PH_IDLE) begin
			if (w.cmd_valid) begin
				case (w.req_type)
					REQ_START: enter_phase(PH_ST0, 1'b1, 1'b1, 9'd1);
					// stop pulls SDA low first, SCL stays where it is
					REQ_STOP:  enter_phase(PH_SP0, m_scl, 1'b0, len);
					REQ_WRITE: begin
						m_shift = w.write_byte;
						m_bits  = '0;
						enter_phase(PH_WHI, 1'b1, w.write_byte[7], len);
					end
					default: begin
						m_shift = '0;
						m_bits  = '0;
						m_ack   = w.master_ack;
						enter_phase(PH_RHI, 1'b1, 1'b1, len);
					end
				endcase
			end
		end else begin
			m_delay = m_delay - 9'd1;
			if (m_delay == '0) begin
				case (m_phase)
					PH_ST0: enter_phase(PH_ST1, 1'b1, 1'b0, len);
					PH_ST1: enter_phase(PH_ST2, 1'b0, 1'b0, len);
					PH_SP0: enter_phase(PH_SP1, 1'b1, 1'b0, len);
					PH_SP1: enter_phase(PH_SP2, 1'b1, 1'b1, len);
					PH_WHI: enter_phase(PH_WLO, 1'b0, m_sda, len);
					PH_WLO: begin
						m_shift = m_shift << 1;
						m_bits  = m_bits + 4'd1;
						// after the eighth bit release SDA for the slave ACK
						if (m_bits >= 4'd8)
							enter_phase(PH_WAH, 1'b1, 1'b1, len);
						else
							enter_phase(PH_WHI, 1'b1, m_shift[7], len);
					end
					PH_WAH: begin
						m_nack = w.sda_in;
						enter_phase(PH_WAL, 1'b0, 1'b1, len);
					end
					PH_RHI: begin
						m_shift = {m_shift[6:0], w.sda_in};
						enter_phase(PH_RLO, 1'b0, 1'b1, len);
					end
					PH_RLO: begin
						m_bits = m_bits + 4'd1;
						if (m_bits >= 4'd8) begin
							m_rd = m_shift;
							enter_phase(PH_RAH, 1'b1, ~m_ack, len);
						end else begin
							enter_phase(PH_RHI, 1'b1, 1'b1, len);
						end
					end
					PH_RAH: enter_phase(PH_RAL, 1'b0, m_sda, len);
					default: fin = 1'b1;
				endcase
				if (fin) begin
					m_phase     = PH_IDLE;
					m_delay     = '0;
					lv.done_res = 1'b1;
				end
			end
		end
		lv.scl_level = m_scl;
		lv.sda_drive = m_sda;
		lv.busy_res  = (m_phase != PH_IDLE);
		lv.read_data = m_rd;
		lv.nack_seen = m_nack;
		return lv;
	endfunction

	// ------------------------------------------------------------- stimulus

	function automatic i2cm_in_t rand_cmd(input logic [1:0] kind);
		i2cm_in_t c;
		c.cmd_valid  = 1'b1;
		c.req_type   = kind;
		c.write_byte = 8'($urandom_range(0, 255));
		c.master_ack = 1'($urandom_range(0, 1));
		c.sda_in     = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Queue one well-formed transfer: start, address byte, a few data bytes,
	// sometimes a repeated start with another byte pair, then stop.
	function automatic void plan_transfer();
		int unsigned n;
		int unsigned k;
		txn_q.push_back(rand_cmd(REQ_START));
		txn_q.push_back(rand_cmd(REQ_WRITE));
		n = $urandom_range(0, 3);
		for (k = 0; k < n; k++)
			txn_q.push_back(rand_cmd($urandom_range(0, 1) ? REQ_READ : REQ_WRITE));
		if ($urandom_range(0, 3) == 0) begin
			txn_q.push_back(rand_cmd(REQ_START));
			txn_q.push_back(rand_cmd(REQ_WRITE));
			txn_q.push_back(rand_cmd(REQ_READ));
		end
		txn_q.push_back(rand_cmd(REQ_STOP));
	endfunction

	// Pick the next tick word from the model's present phase.
	function automatic i2cm_in_t next_word();
		i2cm_in_t w;
		w = rand_cmd(2'($urandom_range(0, 3)));
		if (m_phase != PH_IDLE) begin
			// mostly quiet while busy, now and then a command that must be dropped
			w.cmd_valid = ($urandom_range(0, 3) == 0);
		end else if ($urandom_range(0, 9) == 0) begin
			// noise: any command or none, out of sequence
			w.cmd_valid = 1'($urandom_range(0, 1));
		end else if (txn_q.size() == 0 && $urandom_range(0, 3) == 0) begin
			w.cmd_valid = 1'b0;
		end else begin
			if (txn_q.size() == 0)
				plan_transfer();
			w = txn_q.pop_front();
		end
		w.sda_in = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Offer one word and hold it until taken; record the levels it must produce.
	task automatic put_tick(input i2cm_in_t w, input bit known, input i2cm_out_t typed);
		i2cm_out_t lv;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		lv = step_engine(w);
		pending_levels.push_back(known ? typed : lv);
	endtask

	// Let the running command finish with quiet ticks.
	task automatic run_to_idle();
		i2cm_in_t w;
		while (m_phase != PH_IDLE) begin
			w = rand_cmd(REQ_START);
			w.cmd_valid = 1'b0;
			put_tick(w, 1'b0, '0);
		end
	endtask

	// Write the half period once every result is back and the engine is idle.
	task automatic set_half(input logic [HALF_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		m_half = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_segment(input logic [HALF_W-1:0] half, input int unsigned ticks,
			input seg_mode_t mode);
		int unsigned i;
		calm <= (mode == SEG_CALM);
		set_half(half);
		for (i = 0; i < ticks; i++) begin
			// sender gap burst, none in the calm tail
			if (mode != SEG_CALM && $urandom_range(0, 11) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			// ask the receiver for a long hold while words keep coming
			if (mode == SEG_HOLD && i == ticks / 3)
				hold_reqs <= hold_reqs + 1;
			// stop offering until every predicted word has come back
			if (mode == SEG_PAUSE && i == ticks / 2) begin
				in_valid <= 1'b0;
				while (pending_levels.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			put_tick(next_word(), 1'b0, '0);
		end
		run_to_idle();
		txn_q.delete();
	endtask

	initial begin
		int unsigned r;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// directed commands, opening at the reset half period
		for (r = 0; r < $size(dir_rows); r++) begin
			// shorten the half period once the reset value has timed one start
			if (r == 2)
				set_half(9'd2);
			put_tick(dir_rows[r].cmd, dir_rows[r].known, dir_rows[r].first);
			while (m_phase != PH_IDLE)
				put_tick(dir_rows[r].fill, 1'b0, '0);
		end

		// random transfers over small half periods, zero among them
		run_segment(9'd1, 110, SEG_PLAIN);
		run_segment(9'd0, 110, SEG_HOLD);
		run_segment(9'd3, 110, SEG_PAUSE);
		run_segment(9'd2, 110, SEG_PLAIN);
		run_segment(9'd5, 110, SEG_PLAIN);

		// large half period: one start
		set_half(9'd256);
		put_tick(rand_cmd(REQ_START), 1'b0, '0);
		run_to_idle();

		// tail with no idling on either side
		run_segment(9'd1, 100, SEG_CALM);

		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------- receiver

	task automatic check_word(input i2cm_out_t want, input i2cm_out_t got);
		if (got.scl_level !== want.scl_level) begin
			$display("%0t: scl_level expected %0b got %0b", $time, want.scl_level, got.scl_level);
			fail_count++;
		end
		if (got.sda_drive !== want.sda_drive) begin
			$display("%0t: sda_drive expected %0b got %0b", $time, want.sda_drive, got.sda_drive);
			fail_count++;
		end
		if (got.busy_res !== want.busy_res) begin
			$display("%0t: busy_res expected %0b got %0b", $time, want.busy_res, got.busy_res);
			fail_count++;
		end
		if (got.done_res !== want.done_res) begin
			$display("%0t: done_res expected %0b got %0b", $time, want.done_res, got.done_res);
			fail_count++;
		end
		if (got.read_data !== want.read_data) begin
			$display("%0t: read_data expected %02h got %02h", $time, want.read_data, got.read_data);
			fail_count++;
		end
		if (got.nack_seen !== want.nack_seen) begin
			$display("%0t: nack_seen expected %0b got %0b", $time, want.nack_seen, got.nack_seen);
			fail_count++;
		end
	endtask

	// Take result words against the oldest prediction; drop ready in random
	// bursts, or for one long stretch when the sender asks for it.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$display("%0t: result word %h with none predicted", $time, out_data);
				fail_count++;
			end else begin
				check_word(pending_levels.pop_front(), out_data);
			end
		end
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			rx_gap    = LONG_HOLD;
		end else if (rx_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(1, 17);
		end
		if (rx_gap != 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on total cycles
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
